>>> rtl/core/dsc_pkg.sv
// Shared types, constants and the instruction microprogram of the dual stack CPU core.
package dsc_pkg;

  localparam int unsigned RAM_DEPTH = 65536;
  localparam int unsigned DEV_DEPTH = 256;
  localparam int unsigned STK_DEPTH = 256;
  localparam logic [7:0] STACK_LIMIT = 8'd255;

  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_DEVWR  = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_VECTOR = 3'd3;
  localparam logic [2:0] KIND_STEP   = 3'd4;

  localparam logic [2:0] STAT_RUN       = 3'd0;
  localparam logic [2:0] STAT_IDLE      = 3'd1;
  localparam logic [2:0] STAT_WORK_UNDR = 3'd2;
  localparam logic [2:0] STAT_WORK_OVER = 3'd3;
  localparam logic [2:0] STAT_RET_UNDR  = 3'd4;
  localparam logic [2:0] STAT_RET_OVER  = 3'd5;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_UNDER = 2'd1;
  localparam logic [1:0] FAULT_OVER  = 2'd2;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_READ  = 2'd1;
  localparam logic [1:0] EV_WRITE = 2'd2;

  localparam logic [4:0] OP_BRK = 5'd0;
  localparam logic [4:0] OP_LIT = 5'd1;
  localparam logic [4:0] OP_NOP = 5'd2;
  localparam logic [4:0] OP_POP = 5'd3;
  localparam logic [4:0] OP_DUP = 5'd4;
  localparam logic [4:0] OP_SWP = 5'd5;
  localparam logic [4:0] OP_OVR = 5'd6;
  localparam logic [4:0] OP_ROT = 5'd7;
  localparam logic [4:0] OP_EQU = 5'd8;
  localparam logic [4:0] OP_NEQ = 5'd9;
  localparam logic [4:0] OP_GTH = 5'd10;
  localparam logic [4:0] OP_LTH = 5'd11;
  localparam logic [4:0] OP_JMP = 5'd12;
  localparam logic [4:0] OP_JCN = 5'd13;
  localparam logic [4:0] OP_JSR = 5'd14;
  localparam logic [4:0] OP_STH = 5'd15;
  localparam logic [4:0] OP_LDZ = 5'd16;
  localparam logic [4:0] OP_STZ = 5'd17;
  localparam logic [4:0] OP_LDR = 5'd18;
  localparam logic [4:0] OP_STR = 5'd19;
  localparam logic [4:0] OP_LDA = 5'd20;
  localparam logic [4:0] OP_STA = 5'd21;
  localparam logic [4:0] OP_DEI = 5'd22;
  localparam logic [4:0] OP_DEO = 5'd23;
  localparam logic [4:0] OP_ADD = 5'd24;
  localparam logic [4:0] OP_SUB = 5'd25;
  localparam logic [4:0] OP_MUL = 5'd26;
  localparam logic [4:0] OP_DIV = 5'd27;
  localparam logic [4:0] OP_AND = 5'd28;
  localparam logic [4:0] OP_ORA = 5'd29;
  localparam logic [4:0] OP_EOR = 5'd30;

  typedef enum logic [3:0] {
    U_END, U_POP, U_PUSH, U_MRD, U_MWR, U_DRD, U_DWR, U_PC, U_ALU
  } uop_kind_t;

  typedef enum logic [3:0] {
    R_A_LO, R_A_HI, R_B_LO, R_B_HI, R_C_LO, R_C_HI, R_X,
    R_Y_LO, R_Y_HI, R_PC_LO, R_PC_HI
  } reg_sel_t;

  typedef enum logic [2:0] {
    AD_PC, AD_PC1, AD_X, AD_X1, AD_REL, AD_REL1, AD_A, AD_A1
  } addr_sel_t;

  typedef enum logic [2:0] {
    PS_ZERO, PS_A, PS_REL, PS_INC1, PS_INC2
  } pc_sel_t;

  typedef struct packed {
    uop_kind_t kind;
    logic      other;
    reg_sel_t  rsel;
    addr_sel_t asel;
    pc_sel_t   psel;
    logic      cond;
  } uop_t;

  typedef struct packed {
    logic clr;
    logic host;
    logic mem_cap;
    logic fetch;
    logic decode;
    logic issue;
    logic finish;
    logic fin;
    logic out_sel;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       can_run;
    logic       div_busy;
    logic [7:0] instr;
    logic [1:0] ev_cnt;
  } stat_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HOSTRD, S_FETCH, S_DECODE, S_ISSUE, S_FINISH,
    S_ALU, S_FIN, S_OUT0, S_OUT1
  } state_t;

  function automatic uop_t mk(uop_kind_t k, logic o, reg_sel_t r, addr_sel_t a,
                              pc_sel_t p, logic c);
    uop_t u;
    u.kind  = k;
    u.other = o;
    u.rsel  = r;
    u.asel  = a;
    u.psel  = p;
    u.cond  = c;
    return u;
  endfunction

  function automatic uop_t u_pop(reg_sel_t r);
    return mk(U_POP, 1'b0, r, AD_PC, PS_ZERO, 1'b0);
  endfunction

  function automatic uop_t u_push(reg_sel_t r);
    return mk(U_PUSH, 1'b0, r, AD_PC, PS_ZERO, 1'b0);
  endfunction

  function automatic uop_t u_pushd(reg_sel_t r);
    return mk(U_PUSH, 1'b1, r, AD_PC, PS_ZERO, 1'b0);
  endfunction

  function automatic uop_t u_mem(uop_kind_t k, addr_sel_t a, reg_sel_t r);
    return mk(k, 1'b0, r, a, PS_ZERO, 1'b0);
  endfunction

  function automatic uop_t u_pc(pc_sel_t p, logic c);
    return mk(U_PC, 1'b0, R_A_LO, AD_PC, p, c);
  endfunction

  function automatic uop_t u_end();
    return mk(U_END, 1'b0, R_A_LO, AD_PC, PS_ZERO, 1'b0);
  endfunction

  // Step idx of the micro-sequence for one instruction.
  function automatic uop_t seq_uop(logic [4:0] op, logic w, logic [3:0] idx);
    uop_t      p [16];
    logic [3:0] j;
    addr_sel_t b0;
    addr_sel_t b1;
    for (int i = 0; i < 16; i++) p[i] = u_end();
    j  = 4'd0;
    b0 = AD_X;
    b1 = AD_X1;
    if ((op >= OP_EQU && op <= OP_LTH) || op >= OP_ADD) begin
      if (w) begin
        p[0] = u_pop(R_A_LO);
        p[1] = u_pop(R_A_HI);
        p[2] = u_pop(R_B_LO);
        p[3] = u_pop(R_B_HI);
        p[4] = mk(U_ALU, 1'b0, R_A_LO, AD_PC, PS_ZERO, 1'b0);
        if (op <= OP_LTH) begin
          p[5] = u_push(R_Y_LO);
        end else begin
          p[5] = u_push(R_Y_HI);
          p[6] = u_push(R_Y_LO);
        end
      end else begin
        p[0] = u_pop(R_A_LO);
        p[1] = u_pop(R_B_LO);
        p[2] = mk(U_ALU, 1'b0, R_A_LO, AD_PC, PS_ZERO, 1'b0);
        p[3] = u_push(R_Y_LO);
      end
    end else begin
      case (op)
        OP_BRK: p[0] = u_pc(PS_ZERO, 1'b0);
        OP_LIT: begin
          if (w) begin
            p[0] = u_mem(U_MRD, AD_PC, R_C_HI);
            p[1] = u_mem(U_MRD, AD_PC1, R_C_LO);
            p[2] = u_push(R_C_HI);
            p[3] = u_push(R_C_LO);
            p[4] = u_pc(PS_INC2, 1'b0);
          end else begin
            p[0] = u_mem(U_MRD, AD_PC, R_C_LO);
            p[1] = u_push(R_C_LO);
            p[2] = u_pc(PS_INC1, 1'b0);
          end
        end
        OP_POP: begin
          p[0] = u_pop(R_A_LO);
          if (w) p[1] = u_pop(R_A_HI);
        end
        OP_DUP: begin
          if (w) begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_A_HI);
            p[2] = u_push(R_A_HI);
            p[3] = u_push(R_A_LO);
            p[4] = u_push(R_A_HI);
            p[5] = u_push(R_A_LO);
          end else begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_push(R_A_LO);
            p[2] = u_push(R_A_LO);
          end
        end
        OP_SWP: begin
          if (w) begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_A_HI);
            p[2] = u_pop(R_B_LO);
            p[3] = u_pop(R_B_HI);
            p[4] = u_push(R_A_HI);
            p[5] = u_push(R_A_LO);
            p[6] = u_push(R_B_HI);
            p[7] = u_push(R_B_LO);
          end else begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_B_LO);
            p[2] = u_push(R_A_LO);
            p[3] = u_push(R_B_LO);
          end
        end
        OP_OVR: begin
          if (w) begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_A_HI);
            p[2] = u_pop(R_B_LO);
            p[3] = u_pop(R_B_HI);
            p[4] = u_push(R_B_HI);
            p[5] = u_push(R_B_LO);
            p[6] = u_push(R_A_HI);
            p[7] = u_push(R_A_LO);
            p[8] = u_push(R_B_HI);
            p[9] = u_push(R_B_LO);
          end else begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_B_LO);
            p[2] = u_push(R_B_LO);
            p[3] = u_push(R_A_LO);
            p[4] = u_push(R_B_LO);
          end
        end
        OP_ROT: begin
          if (w) begin
            p[0]  = u_pop(R_A_LO);
            p[1]  = u_pop(R_A_HI);
            p[2]  = u_pop(R_B_LO);
            p[3]  = u_pop(R_B_HI);
            p[4]  = u_pop(R_C_LO);
            p[5]  = u_pop(R_C_HI);
            p[6]  = u_push(R_B_HI);
            p[7]  = u_push(R_B_LO);
            p[8]  = u_push(R_A_HI);
            p[9]  = u_push(R_A_LO);
            p[10] = u_push(R_C_HI);
            p[11] = u_push(R_C_LO);
          end else begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_B_LO);
            p[2] = u_pop(R_C_LO);
            p[3] = u_push(R_B_LO);
            p[4] = u_push(R_A_LO);
            p[5] = u_push(R_C_LO);
          end
        end
        OP_JMP: begin
          if (w) begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_A_HI);
            p[2] = u_pc(PS_A, 1'b0);
          end else begin
            p[0] = u_pop(R_X);
            p[1] = u_pc(PS_REL, 1'b0);
          end
        end
        OP_JCN: begin
          if (w) begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_A_HI);
            p[2] = u_pop(R_B_LO);
            p[3] = u_pc(PS_A, 1'b1);
          end else begin
            p[0] = u_pop(R_X);
            p[1] = u_pop(R_B_LO);
            p[2] = u_pc(PS_REL, 1'b1);
          end
        end
        OP_JSR: begin
          if (w) begin
            p[0] = u_pushd(R_PC_HI);
            p[1] = u_pushd(R_PC_LO);
            p[2] = u_pop(R_A_LO);
            p[3] = u_pop(R_A_HI);
            p[4] = u_pc(PS_A, 1'b0);
          end else begin
            p[0] = u_pop(R_X);
            p[1] = u_pushd(R_PC_HI);
            p[2] = u_pushd(R_PC_LO);
            p[3] = u_pc(PS_REL, 1'b0);
          end
        end
        OP_STH: begin
          if (w) begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_A_HI);
            p[2] = u_pushd(R_A_HI);
            p[3] = u_pushd(R_A_LO);
          end else begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pushd(R_A_LO);
          end
        end
        OP_LDZ, OP_LDR, OP_LDA: begin
          if (op == OP_LDA) begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_A_HI);
            j  = 4'd2;
            b0 = AD_A;
            b1 = AD_A1;
          end else begin
            p[0] = u_pop(R_X);
            j  = 4'd1;
            b0 = (op == OP_LDR) ? AD_REL : AD_X;
            b1 = (op == OP_LDR) ? AD_REL1 : AD_X1;
          end
          if (w) begin
            p[j]        = u_mem(U_MRD, b0, R_C_HI);
            p[j + 4'd1] = u_mem(U_MRD, b1, R_C_LO);
            p[j + 4'd2] = u_push(R_C_HI);
            p[j + 4'd3] = u_push(R_C_LO);
          end else begin
            p[j]        = u_mem(U_MRD, b0, R_C_LO);
            p[j + 4'd1] = u_push(R_C_LO);
          end
        end
        OP_STZ, OP_STR, OP_STA: begin
          if (op == OP_STA) begin
            p[0] = u_pop(R_A_LO);
            p[1] = u_pop(R_A_HI);
            j  = 4'd2;
            b0 = AD_A;
            b1 = AD_A1;
          end else begin
            p[0] = u_pop(R_X);
            j  = 4'd1;
            b0 = (op == OP_STR) ? AD_REL : AD_X;
            b1 = (op == OP_STR) ? AD_REL1 : AD_X1;
          end
          if (w) begin
            p[j]        = u_pop(R_B_LO);
            p[j + 4'd1] = u_pop(R_B_HI);
            p[j + 4'd2] = u_mem(U_MWR, b0, R_B_HI);
            p[j + 4'd3] = u_mem(U_MWR, b1, R_B_LO);
          end else begin
            p[j]        = u_pop(R_B_LO);
            p[j + 4'd1] = u_mem(U_MWR, b0, R_B_LO);
          end
        end
        OP_DEI: begin
          p[0] = u_pop(R_X);
          if (w) begin
            p[1] = u_mem(U_DRD, AD_X, R_C_HI);
            p[2] = u_mem(U_DRD, AD_X1, R_C_LO);
            p[3] = u_push(R_C_HI);
            p[4] = u_push(R_C_LO);
          end else begin
            p[1] = u_mem(U_DRD, AD_X, R_C_LO);
            p[2] = u_push(R_C_LO);
          end
        end
        OP_DEO: begin
          p[0] = u_pop(R_X);
          if (w) begin
            p[1] = u_pop(R_B_LO);
            p[2] = u_pop(R_B_HI);
            p[3] = u_mem(U_DWR, AD_X, R_B_HI);
            p[4] = u_mem(U_DWR, AD_X1, R_B_LO);
          end else begin
            p[1] = u_pop(R_B_LO);
            p[2] = u_mem(U_DWR, AD_X, R_B_LO);
          end
        end
        default: p[0] = u_end();
      endcase
    end
    return p[idx];
  endfunction

endpackage

>>> rtl/core/dsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dsc_ctrl.sv
// Controller state machine that sequences host beats and instruction micro-steps.
module dsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        kind,
  output logic              out_valid,
  input  logic              out_stall,
  input  dsc_pkg::stat_t    stat,
  output dsc_pkg::cmd_t     cmd
);

  dsc_pkg::state_t state, state_next;
  logic [3:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsc_pkg::S_CLEAR;
      idx   <= 4'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    cmd        = '0;
    cmd.uop    = dsc_pkg::seq_uop(stat.instr[4:0], stat.instr[5], idx);
    unique case (state)
      dsc_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_next = dsc_pkg::S_IDLE;
      end
      dsc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.host = 1'b1;
          if (kind == dsc_pkg::KIND_READ) begin
            state_next = dsc_pkg::S_HOSTRD;
          end else if (kind == dsc_pkg::KIND_STEP && stat.can_run) begin
            state_next = dsc_pkg::S_FETCH;
          end else begin
            state_next = dsc_pkg::S_OUT0;
          end
        end
      end
      dsc_pkg::S_HOSTRD: begin
        cmd.mem_cap = 1'b1;
        state_next  = dsc_pkg::S_OUT0;
      end
      dsc_pkg::S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = dsc_pkg::S_DECODE;
      end
      dsc_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        idx_next   = 4'd0;
        state_next = dsc_pkg::S_ISSUE;
      end
      dsc_pkg::S_ISSUE: begin
        cmd.issue = 1'b1;
        if (cmd.uop.kind == dsc_pkg::U_END) begin
          state_next = dsc_pkg::S_FIN;
        end else if (cmd.uop.kind == dsc_pkg::U_ALU) begin
          state_next = dsc_pkg::S_ALU;
        end else begin
          state_next = dsc_pkg::S_FINISH;
        end
      end
      dsc_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        idx_next   = idx + 4'd1;
        state_next = dsc_pkg::S_ISSUE;
      end
      dsc_pkg::S_ALU: begin
        if (!stat.div_busy) begin
          idx_next   = idx + 4'd1;
          state_next = dsc_pkg::S_ISSUE;
        end
      end
      dsc_pkg::S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = dsc_pkg::S_OUT0;
      end
      dsc_pkg::S_OUT0: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = (stat.ev_cnt == 2'd2) ? dsc_pkg::S_OUT1 : dsc_pkg::S_IDLE;
        end
      end
      dsc_pkg::S_OUT1: begin
        out_valid   = 1'b1;
        cmd.out_sel = 1'b1;
        if (!out_stall) state_next = dsc_pkg::S_IDLE;
      end
      default: state_next = dsc_pkg::S_CLEAR;
    endcase
  end

endmodule

>>> rtl/core/dsc_dpath.sv
// Datapath with memories, stack pointers, operand registers, ALU and divider.
module dsc_dpath (
  input  logic           clk,
  input  logic           rst,
  input  dsc_pkg::cmd_t  cmd,
  input  logic [2:0]     kind,
  input  logic [15:0]    addr,
  input  logic [7:0]     data,
  output dsc_pkg::stat_t stat,
  output logic [2:0]     status,
  output logic [15:0]    pc_now,
  output logic [1:0]     dev_event,
  output logic [7:0]     dev_addr,
  output logic [7:0]     dev_data,
  output logic [7:0]     mem_data,
  output logic           last
);

  logic [15:0] pc;
  logic [7:0]  top [2];
  logic [7:0]  keep [2];
  logic [1:0]  fault [2];
  logic [7:0]  instr;
  logic [15:0] ra, rb, rc, ry;
  logic [7:0]  rx;
  logic        pend_zero;
  logic [7:0]  mem_q;
  logic [1:0]  ev_cnt;
  logic [1:0]  ev_kind [2];
  logic [7:0]  ev_addr [2];
  logic [7:0]  ev_data [2];
  logic [15:0] clr_cnt;
  logic        div_busy;
  logic [3:0]  div_cnt;
  logic [15:0] div_q, div_r;

  dsc_pkg::uop_t uop;
  logic        sid;
  logic        keep_m;
  logic [7:0]  ptr;
  logic [7:0]  src;
  logic [15:0] rel, ea, pc_sel;
  logic [7:0]  port;
  logic [15:0] ram_raddr, ram_waddr;
  logic [7:0]  ram_wdata, ram_rdata;
  logic        ram_we;
  logic [7:0]  dev_raddr, dev_waddr, dev_wdata, dev_rdata;
  logic        dev_we;
  logic [7:0]  stk_waddr, stk_wdata, stk_raddr;
  logic [7:0]  stk_rdata [2];
  logic        stk_we [2];
  logic        push_ok;
  logic [15:0] alu_y;
  logic [31:0] prod;
  logic [16:0] div_rs;
  logic        div_ge;
  logic [15:0] div_rn;
  logic        ld_en;
  logic [7:0]  ld_val;
  logic        ev_en;
  logic [1:0]  ev_k;
  logic [7:0]  ev_d;

  assign uop    = cmd.uop;
  assign sid    = instr[6] ^ uop.other;
  assign keep_m = instr[7];
  assign ptr    = keep_m ? keep[sid] : top[sid];
  assign push_ok = top[sid] < dsc_pkg::STACK_LIMIT;
  assign rel    = pc + {{8{rx[7]}}, rx};
  assign port   = (uop.asel == dsc_pkg::AD_X1) ? {rx[7:4], rx[3:0] + 4'd1} : rx;

  always_comb begin
    unique case (uop.rsel)
      dsc_pkg::R_A_LO:  src = ra[7:0];
      dsc_pkg::R_A_HI:  src = ra[15:8];
      dsc_pkg::R_B_LO:  src = rb[7:0];
      dsc_pkg::R_B_HI:  src = rb[15:8];
      dsc_pkg::R_C_LO:  src = rc[7:0];
      dsc_pkg::R_C_HI:  src = rc[15:8];
      dsc_pkg::R_X:     src = rx;
      dsc_pkg::R_Y_LO:  src = ry[7:0];
      dsc_pkg::R_Y_HI:  src = ry[15:8];
      dsc_pkg::R_PC_LO: src = pc[7:0];
      dsc_pkg::R_PC_HI: src = pc[15:8];
      default:          src = 8'd0;
    endcase
  end

  always_comb begin
    unique case (uop.asel)
      dsc_pkg::AD_PC:   ea = pc;
      dsc_pkg::AD_PC1:  ea = pc + 16'd1;
      dsc_pkg::AD_X:    ea = {8'd0, rx};
      dsc_pkg::AD_X1:   ea = {8'd0, rx} + 16'd1;
      dsc_pkg::AD_REL:  ea = rel;
      dsc_pkg::AD_REL1: ea = rel + 16'd1;
      dsc_pkg::AD_A:    ea = ra;
      dsc_pkg::AD_A1:   ea = ra + 16'd1;
      default:          ea = pc;
    endcase
  end

  always_comb begin
    unique case (uop.psel)
      dsc_pkg::PS_ZERO: pc_sel = 16'd0;
      dsc_pkg::PS_A:    pc_sel = ra;
      dsc_pkg::PS_REL:  pc_sel = rel;
      dsc_pkg::PS_INC1: pc_sel = pc + 16'd1;
      dsc_pkg::PS_INC2: pc_sel = pc + 16'd2;
      default:          pc_sel = pc;
    endcase
  end

  assign prod = 32'(rb) * 32'(ra);

  always_comb begin
    case (instr[4:0])
      dsc_pkg::OP_EQU: alu_y = {15'd0, rb == ra};
      dsc_pkg::OP_NEQ: alu_y = {15'd0, rb != ra};
      dsc_pkg::OP_GTH: alu_y = {15'd0, rb > ra};
      dsc_pkg::OP_LTH: alu_y = {15'd0, rb < ra};
      dsc_pkg::OP_ADD: alu_y = rb + ra;
      dsc_pkg::OP_SUB: alu_y = rb - ra;
      dsc_pkg::OP_MUL: alu_y = prod[15:0];
      dsc_pkg::OP_DIV: alu_y = 16'd0;
      dsc_pkg::OP_AND: alu_y = rb & ra;
      dsc_pkg::OP_ORA: alu_y = rb | ra;
      dsc_pkg::OP_EOR: alu_y = rb ^ ra;
      default: begin
        if (instr[5]) alu_y = (rb >> ra[3:0]) << ra[7:4];
        else          alu_y = (rb >> ra[2:0]) << ra[6:4];
      end
    endcase
  end

  assign div_rs = {div_r, div_q[15]};
  assign div_ge = div_rs >= {1'b0, ra};
  assign div_rn = div_ge ? 16'(div_rs - {1'b0, ra}) : div_rs[15:0];

  always_comb begin
    ram_raddr = cmd.host ? addr : (cmd.fetch ? pc : ea);
    ram_we    = 1'b0;
    ram_waddr = ea;
    ram_wdata = src;
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = 8'd0;
    end else if (cmd.host && kind == dsc_pkg::KIND_LOAD) begin
      ram_we    = 1'b1;
      ram_waddr = addr;
      ram_wdata = data;
    end else if (cmd.issue && uop.kind == dsc_pkg::U_MWR) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    dev_raddr = port;
    dev_we    = 1'b0;
    dev_waddr = port;
    dev_wdata = src;
    if (cmd.clr) begin
      dev_we    = 1'b1;
      dev_waddr = clr_cnt[7:0];
      dev_wdata = 8'd0;
    end else if (cmd.host && kind == dsc_pkg::KIND_DEVWR) begin
      dev_we    = 1'b1;
      dev_waddr = addr[7:0];
      dev_wdata = data;
    end else if (cmd.issue && uop.kind == dsc_pkg::U_DWR) begin
      dev_we = 1'b1;
    end
  end

  always_comb begin
    stk_raddr = ptr - 8'd1;
    stk_waddr = cmd.clr ? clr_cnt[7:0] : top[sid];
    stk_wdata = cmd.clr ? 8'd0 : src;
    for (int i = 0; i < 2; i++) begin
      stk_we[i] = cmd.clr || (cmd.issue && uop.kind == dsc_pkg::U_PUSH &&
                              sid == 1'(i) && push_ok);
    end
  end

  always_comb begin
    ld_en  = cmd.finish && (uop.kind == dsc_pkg::U_POP || uop.kind == dsc_pkg::U_MRD ||
                            uop.kind == dsc_pkg::U_DRD);
    ld_val = dev_rdata;
    if (uop.kind == dsc_pkg::U_POP)      ld_val = pend_zero ? 8'd0 : stk_rdata[sid];
    else if (uop.kind == dsc_pkg::U_MRD) ld_val = ram_rdata;
    ev_en = (cmd.issue && uop.kind == dsc_pkg::U_DWR) ||
            (cmd.finish && uop.kind == dsc_pkg::U_DRD);
    ev_k  = (uop.kind == dsc_pkg::U_DWR) ? dsc_pkg::EV_WRITE : dsc_pkg::EV_READ;
    ev_d  = (uop.kind == dsc_pkg::U_DWR) ? src : dev_rdata;
  end

  dsc_ram #(.WIDTH(8), .DEPTH(dsc_pkg::RAM_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  dsc_ram #(.WIDTH(8), .DEPTH(dsc_pkg::DEV_DEPTH)) u_dev (
    .clk(clk), .we(dev_we), .waddr(dev_waddr), .wdata(dev_wdata),
    .raddr(dev_raddr), .rdata(dev_rdata)
  );

  dsc_ram #(.WIDTH(8), .DEPTH(dsc_pkg::STK_DEPTH)) u_wstk (
    .clk(clk), .we(stk_we[0]), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata[0])
  );

  dsc_ram #(.WIDTH(8), .DEPTH(dsc_pkg::STK_DEPTH)) u_rstk (
    .clk(clk), .we(stk_we[1]), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata[1])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= 16'd0;
      top[0]   <= 8'd0;
      top[1]   <= 8'd0;
      keep[0]  <= 8'd0;
      keep[1]  <= 8'd0;
      fault[0] <= dsc_pkg::FAULT_NONE;
      fault[1] <= dsc_pkg::FAULT_NONE;
      ev_cnt   <= 2'd0;
      clr_cnt  <= 16'd0;
      div_busy <= 1'b0;
      div_cnt  <= 4'd0;
      instr    <= 8'd0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + 16'd1;
      if (cmd.host) begin
        mem_q  <= 8'd0;
        ev_cnt <= 2'd0;
        for (int i = 0; i < 2; i++) begin
          ev_kind[i] <= dsc_pkg::EV_NONE;
          ev_addr[i] <= 8'd0;
          ev_data[i] <= 8'd0;
        end
        if (kind == dsc_pkg::KIND_VECTOR) begin
          pc       <= addr;
          fault[0] <= dsc_pkg::FAULT_NONE;
          fault[1] <= dsc_pkg::FAULT_NONE;
        end
      end
      if (cmd.mem_cap) mem_q <= ram_rdata;
      if (cmd.decode) begin
        instr <= ram_rdata;
        pc    <= pc + 16'd1;
        ra    <= 16'd0;
        rb    <= 16'd0;
        rc    <= 16'd0;
        ry    <= 16'd0;
        rx    <= 8'd0;
        if (ram_rdata[7]) keep[ram_rdata[6]] <= top[ram_rdata[6]];
      end
      if (cmd.issue) begin
        case (uop.kind)
          dsc_pkg::U_POP: begin
            if (ptr == 8'd0) begin
              fault[sid] <= dsc_pkg::FAULT_UNDER;
              pend_zero  <= 1'b1;
            end else begin
              pend_zero <= 1'b0;
              if (keep_m) keep[sid] <= ptr - 8'd1;
              else        top[sid]  <= ptr - 8'd1;
            end
          end
          dsc_pkg::U_PUSH: begin
            if (push_ok) top[sid]   <= top[sid] + 8'd1;
            else         fault[sid] <= dsc_pkg::FAULT_OVER;
          end
          dsc_pkg::U_PC: begin
            if (!uop.cond || rb[7:0] != 8'd0) pc <= pc_sel;
          end
          dsc_pkg::U_ALU: begin
            if (instr[4:0] == dsc_pkg::OP_DIV && ra != 16'd0) begin
              div_busy <= 1'b1;
              div_cnt  <= 4'd0;
              div_q    <= rb;
              div_r    <= 16'd0;
            end else begin
              ry <= alu_y;
            end
          end
          default: ;
        endcase
      end
      if (ld_en) begin
        case (uop.rsel)
          dsc_pkg::R_A_LO: ra[7:0]  <= ld_val;
          dsc_pkg::R_A_HI: ra[15:8] <= ld_val;
          dsc_pkg::R_B_LO: rb[7:0]  <= ld_val;
          dsc_pkg::R_B_HI: rb[15:8] <= ld_val;
          dsc_pkg::R_C_LO: rc[7:0]  <= ld_val;
          dsc_pkg::R_C_HI: rc[15:8] <= ld_val;
          dsc_pkg::R_X:    rx       <= ld_val;
          default: ;
        endcase
      end
      if (ev_en && ev_cnt != 2'd2) begin
        ev_kind[ev_cnt[0]] <= ev_k;
        ev_addr[ev_cnt[0]] <= port;
        ev_data[ev_cnt[0]] <= ev_d;
        ev_cnt             <= ev_cnt + 2'd1;
      end
      if (div_busy) begin
        div_r   <= div_rn;
        div_q   <= {div_q[14:0], div_ge};
        div_cnt <= div_cnt + 4'd1;
        if (div_cnt == 4'd15) begin
          div_busy <= 1'b0;
          ry       <= {div_q[14:0], div_ge};
        end
      end
      if (cmd.fin && (fault[0] != dsc_pkg::FAULT_NONE || fault[1] != dsc_pkg::FAULT_NONE)) begin
        pc <= 16'd0;
      end
    end
  end

  always_comb begin
    if (fault[0] != dsc_pkg::FAULT_NONE) begin
      status = (fault[0] == dsc_pkg::FAULT_UNDER) ? dsc_pkg::STAT_WORK_UNDR
                                                  : dsc_pkg::STAT_WORK_OVER;
    end else if (fault[1] != dsc_pkg::FAULT_NONE) begin
      status = (fault[1] == dsc_pkg::FAULT_UNDER) ? dsc_pkg::STAT_RET_UNDR
                                                  : dsc_pkg::STAT_RET_OVER;
    end else begin
      status = (pc == 16'd0) ? dsc_pkg::STAT_IDLE : dsc_pkg::STAT_RUN;
    end
  end

  assign pc_now    = pc;
  assign dev_event = ev_kind[cmd.out_sel];
  assign dev_addr  = ev_addr[cmd.out_sel];
  assign dev_data  = ev_data[cmd.out_sel];
  assign mem_data  = mem_q;
  assign last      = cmd.out_sel || ev_cnt != 2'd2;

  assign stat.clr_done = clr_cnt == 16'hFFFF;
  assign stat.can_run  = pc != 16'd0 && fault[0] == dsc_pkg::FAULT_NONE &&
                         fault[1] == dsc_pkg::FAULT_NONE;
  assign stat.div_busy = div_busy;
  assign stat.instr    = instr;
  assign stat.ev_cnt   = ev_cnt;

endmodule

>>> rtl/core/dual_stack_cpu_core.sv
// Top level of the dual stack CPU core: controller and datapath.
// The input channel carries host beats (kind, addr, data): load a RAM byte,
// write a device byte, read a RAM byte, start a vector at addr, or step one
// instruction. The output channel returns one result beat per item, or two
// beats for a step that reads or writes two device bytes; last marks the
// final beat of an item. Both channels use valid and stall.
// One item is handled at a time. Load, device write and vector items and a step
// that cannot run go straight to their result beat; a RAM read first captures
// the byte. A step that runs fetches and decodes the instruction, then issues and
// finishes each micro-step of the instruction (a stack, RAM or device access, a
// program counter update or an ALU operation; up to 12 of them), waits for the
// divider on a division, and may give a second result beat.
// The ALU micro-step has a state of its own, where a division holds the sequencer.
// After reset the block clears RAM, device store and both stacks, one address
// a cycle, while in_stall stays high.
// While out_stall is high the result beat holds, and no new item is taken.
module dual_stack_cpu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] pc_now,
  output logic [1:0]  dev_event,
  output logic [7:0]  dev_addr,
  output logic [7:0]  dev_data,
  output logic [7:0]  mem_data,
  output logic        last
);

  dsc_pkg::cmd_t  cmd;
  dsc_pkg::stat_t stat;

  dsc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  dsc_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd),
    .kind(kind), .addr(addr), .data(data),
    .stat(stat), .status(status), .pc_now(pc_now),
    .dev_event(dev_event), .dev_addr(dev_addr), .dev_data(dev_data),
    .mem_data(mem_data), .last(last)
  );

endmodule

>>> test/dual_stack_cpu_core_tb.sv
// Self-checking testbench of the dual stack CPU core: directed and random host beats.
`timescale 1ns / 1ps

module dual_stack_cpu_core_tb;
  import dsc_pkg::*;

  typedef struct packed {
    logic [2:0]  st;
    logic [15:0] pc;
    logic [1:0]  ev;
    logic [7:0]  da;
    logic [7:0]  dd;
    logic [7:0]  md;
    logic        lst;
  } beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        chk;
    logic [2:0]  st;
    logic [15:0] pc;
    logic [7:0]  md;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [15:0] addr;
  logic [7:0]  data;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [15:0] pc_now;
  logic [1:0]  dev_event;
  logic [7:0]  dev_addr;
  logic [7:0]  dev_data;
  logic [7:0]  mem_data;
  logic        last;

  dual_stack_cpu_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .addr(addr), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .pc_now(pc_now), .dev_event(dev_event),
    .dev_addr(dev_addr), .dev_data(dev_data), .mem_data(mem_data), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the machine state.
  logic [7:0]  ram [65536];
  logic [7:0]  dev [256];
  logic [7:0]  stk [2][256];
  logic [7:0]  top [2];
  logic [7:0]  keep [2];
  logic [1:0]  flt [2];
  logic [15:0] pc;
  logic        keepm;
  int          evn;
  logic [1:0]  ev_k [2];
  logic [7:0]  ev_a [2];
  logic [7:0]  ev_d [2];

  beat_t beats_due [$];
  int    errors = 0;
  int    sent = 0;
  int    burst_left = 0;
  bit    hold_req = 0;

  function automatic void push8(int s, logic [7:0] v);
    if (top[s] >= STACK_LIMIT) begin
      flt[s] = FAULT_OVER;
      return;
    end
    stk[s][top[s]] = v;
    top[s] = top[s] + 8'd1;
  endfunction

  function automatic logic [7:0] pop8(int s);
    if (keepm) begin
      if (keep[s] == 8'd0) begin
        flt[s] = FAULT_UNDER;
        return 8'd0;
      end
      keep[s] = keep[s] - 8'd1;
      return stk[s][keep[s]];
    end
    if (top[s] == 8'd0) begin
      flt[s] = FAULT_UNDER;
      return 8'd0;
    end
    top[s] = top[s] - 8'd1;
    return stk[s][top[s]];
  endfunction

  function automatic void push16(int s, logic [15:0] v);
    push8(s, v[15:8]);
    push8(s, v[7:0]);
  endfunction

  function automatic logic [15:0] pop16(int s);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = pop8(s);
    hi = pop8(s);
    return {hi, lo};
  endfunction

  function automatic logic [15:0] peek16(logic [15:0] a);
    return {ram[a], ram[a + 16'd1]};
  endfunction

  function automatic void poke16(logic [15:0] a, logic [15:0] v);
    ram[a] = v[15:8];
    ram[a + 16'd1] = v[7:0];
  endfunction

  function automatic void note_event(logic [1:0] k, logic [7:0] a, logic [7:0] d);
    if (evn >= 2) return;
    ev_k[evn] = k;
    ev_a[evn] = a;
    ev_d[evn] = d;
    evn++;
  endfunction

  function automatic logic [7:0] dev_rd(logic [7:0] a);
    note_event(EV_READ, a, dev[a]);
    return dev[a];
  endfunction

  function automatic void dev_wr(logic [7:0] a, logic [7:0] v);
    dev[a] = v;
    note_event(EV_WRITE, a, v);
  endfunction

  function automatic logic [7:0] nport(logic [7:0] a);
    return {a[7:4], a[3:0] + 4'd1};
  endfunction

  function automatic logic [15:0] rel(logic [15:0] base, logic [7:0] off);
    return base + {{8{off[7]}}, off};
  endfunction

  function automatic logic [31:0] calc(logic [4:0] op, logic [31:0] b, logic [31:0] a,
                                       logic w);
    case (op)
      OP_EQU: return 32'(b == a);
      OP_NEQ: return 32'(b != a);
      OP_GTH: return 32'(b > a);
      OP_LTH: return 32'(b < a);
      OP_ADD: return b + a;
      OP_SUB: return b - a;
      OP_MUL: return b * a;
      OP_DIV: return (a != 0) ? b / a : 32'd0;
      OP_AND: return b & a;
      OP_ORA: return b | a;
      OP_EOR: return b ^ a;
      default: begin
        if (w) return (b >> a[3:0]) << a[7:4];
        return (b >> a[2:0]) << a[6:4];
      end
    endcase
  endfunction

  function automatic void run_instr(logic [7:0] ins);
    logic [4:0]  op;
    logic        w;
    int          s;
    int          d;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [7:0]  x;
    op = ins[4:0];
    w = ins[5];
    s = ins[6];
    d = 1 - s;
    keepm = ins[7];
    if (keepm) keep[s] = top[s];
    if ((op >= OP_EQU && op <= OP_LTH) || op >= OP_ADD) begin
      if (w) begin
        a = pop16(s);
        b = pop16(s);
        if (op <= OP_LTH) push8(s, 8'(calc(op, 32'(b), 32'(a), 1'b1)));
        else push16(s, 16'(calc(op, 32'(b), 32'(a), 1'b1)));
      end else begin
        a = 16'(pop8(s));
        b = 16'(pop8(s));
        push8(s, 8'(calc(op, 32'(b), 32'(a), 1'b0)));
      end
      return;
    end
    case (op)
      OP_BRK: pc = 16'd0;
      OP_LIT: begin
        if (w) begin
          push16(s, peek16(pc));
          pc = pc + 16'd2;
        end else begin
          push8(s, ram[pc]);
          pc = pc + 16'd1;
        end
      end
      OP_NOP: ;
      OP_POP: begin
        if (w) a = pop16(s);
        else x = pop8(s);
      end
      OP_DUP: begin
        if (w) begin
          a = pop16(s); push16(s, a); push16(s, a);
        end else begin
          x = pop8(s); push8(s, x); push8(s, x);
        end
      end
      OP_SWP: begin
        if (w) begin
          a = pop16(s); b = pop16(s); push16(s, a); push16(s, b);
        end else begin
          a = 16'(pop8(s)); b = 16'(pop8(s)); push8(s, a[7:0]); push8(s, b[7:0]);
        end
      end
      OP_OVR: begin
        if (w) begin
          a = pop16(s); b = pop16(s); push16(s, b); push16(s, a); push16(s, b);
        end else begin
          a = 16'(pop8(s)); b = 16'(pop8(s));
          push8(s, b[7:0]); push8(s, a[7:0]); push8(s, b[7:0]);
        end
      end
      OP_ROT: begin
        if (w) begin
          a = pop16(s); b = pop16(s); c = pop16(s);
          push16(s, b); push16(s, a); push16(s, c);
        end else begin
          a = 16'(pop8(s)); b = 16'(pop8(s)); c = 16'(pop8(s));
          push8(s, b[7:0]); push8(s, a[7:0]); push8(s, c[7:0]);
        end
      end
      OP_JMP: begin
        if (w) pc = pop16(s);
        else begin
          x = pop8(s); pc = rel(pc, x);
        end
      end
      OP_JCN: begin
        if (w) begin
          a = pop16(s);
          if (pop8(s) != 8'd0) pc = a;
        end else begin
          x = pop8(s);
          if (pop8(s) != 8'd0) pc = rel(pc, x);
        end
      end
      OP_JSR: begin
        if (w) begin
          push16(d, pc); pc = pop16(s);
        end else begin
          x = pop8(s); push16(d, pc); pc = rel(pc, x);
        end
      end
      OP_STH: begin
        if (w) push16(d, pop16(s));
        else push8(d, pop8(s));
      end
      OP_LDZ: begin
        x = pop8(s);
        if (w) push16(s, peek16({8'd0, x}));
        else push8(s, ram[{8'd0, x}]);
      end
      OP_STZ: begin
        x = pop8(s);
        if (w) poke16({8'd0, x}, pop16(s));
        else ram[{8'd0, x}] = pop8(s);
      end
      OP_LDR: begin
        x = pop8(s);
        if (w) push16(s, peek16(rel(pc, x)));
        else push8(s, ram[rel(pc, x)]);
      end
      OP_STR: begin
        x = pop8(s);
        if (w) poke16(rel(pc, x), pop16(s));
        else ram[rel(pc, x)] = pop8(s);
      end
      OP_LDA: begin
        a = pop16(s);
        if (w) push16(s, peek16(a));
        else push8(s, ram[a]);
      end
      OP_STA: begin
        a = pop16(s);
        if (w) poke16(a, pop16(s));
        else ram[a] = pop8(s);
      end
      OP_DEI: begin
        x = pop8(s);
        if (w) begin
          b = 16'(dev_rd(x));
          c = 16'(dev_rd(nport(x)));
          push16(s, {b[7:0], c[7:0]});
        end else push8(s, dev_rd(x));
      end
      default: begin
        x = pop8(s);
        if (w) begin
          b = pop16(s);
          dev_wr(x, b[15:8]);
          dev_wr(nport(x), b[7:0]);
        end else dev_wr(x, pop8(s));
      end
    endcase
  endfunction

  function automatic logic [2:0] status_of();
    if (flt[0] != FAULT_NONE) return (flt[0] == FAULT_UNDER) ? STAT_WORK_UNDR : STAT_WORK_OVER;
    if (flt[1] != FAULT_NONE) return (flt[1] == FAULT_UNDER) ? STAT_RET_UNDR : STAT_RET_OVER;
    return (pc == 16'd0) ? STAT_IDLE : STAT_RUN;
  endfunction

  task automatic predict_item(logic [2:0] k, logic [15:0] a, logic [7:0] d);
    logic [7:0] md;
    logic [7:0] ins;
    int         n;
    beat_t      bt;
    md = 8'd0;
    evn = 0;
    case (k)
      KIND_LOAD:  ram[a] = d;
      KIND_DEVWR: dev[a[7:0]] = d;
      KIND_READ:  md = ram[a];
      KIND_VECTOR: begin
        pc = a;
        flt[0] = FAULT_NONE;
        flt[1] = FAULT_NONE;
      end
      KIND_STEP: begin
        if (pc != 16'd0 && flt[0] == FAULT_NONE && flt[1] == FAULT_NONE) begin
          ins = ram[pc];
          pc = pc + 16'd1;
          run_instr(ins);
          if (flt[0] != FAULT_NONE || flt[1] != FAULT_NONE) pc = 16'd0;
        end
      end
      default: ;
    endcase
    n = (evn != 0) ? evn : 1;
    for (int i = 0; i < n; i++) begin
      bt.st  = status_of();
      bt.pc  = pc;
      bt.ev  = (evn != 0) ? ev_k[i] : EV_NONE;
      bt.da  = (evn != 0) ? ev_a[i] : 8'd0;
      bt.dd  = (evn != 0) ? ev_d[i] : 8'd0;
      bt.md  = md;
      bt.lst = (i == n - 1);
      beats_due.push_back(bt);
    end
  endtask

  task automatic offer(logic [2:0] k, logic [15:0] a, logic [7:0] d);
    kind <= k;
    addr <= a;
    data <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_item(k, a, d);
    sent++;
  endtask

  task automatic pause();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 14);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send(logic [2:0] k, logic [15:0] a, logic [7:0] d);
    offer(k, a, d);
    pause();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_program();
    logic [15:0] base;
    logic [7:0]  b;
    int          len;
    base = 16'($urandom_range(1, 65535));
    len = $urandom_range(1, 10);
    if ($urandom_range(0, 2) == 0)
      send(KIND_DEVWR, 16'($urandom), 8'($urandom));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if ($urandom_range(0, 2) == 0) b = (b & 8'he0) | {3'd0, OP_LIT};
      send(KIND_LOAD, base + 16'(i), b);
    end
    send(KIND_VECTOR, base, 8'($urandom));
    repeat (len + $urandom_range(0, 3)) send(KIND_STEP, 16'($urandom), 8'($urandom));
  endtask

  // Fills one stack until it overflows: a literal, then a run of byte duplicates.
  task automatic flood(logic ret_side);
    send(KIND_LOAD, 16'h0300, {1'b0, ret_side, 1'b0, OP_LIT});
    send(KIND_LOAD, 16'h0301, 8'h5a);
    for (int i = 0; i < 258; i++)
      send(KIND_LOAD, 16'h0302 + 16'(i), {1'b0, ret_side, 1'b0, OP_DUP});
    send(KIND_VECTOR, 16'h0300, 8'h00);
    repeat (260) send(KIND_STEP, 16'h0000, 8'h00);
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, pc_now, dev_event, dev_addr, dev_data, mem_data, last};
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
      end else begin
        want = beats_due.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected st=%0d pc=%h ev=%0d da=%h dd=%h md=%h last=%b",
                   $time, want.st, want.pc, want.ev, want.da, want.dd, want.md, want.lst);
          $display("%0t:          actual   st=%0d pc=%h ev=%0d da=%h dd=%h md=%h last=%b",
                   $time, got.st, got.pc, got.ev, got.da, got.dd, got.md, got.lst);
          errors++;
        end
      end
    end
  end

  initial begin
    int seg;
    int mode;
    out_stall = 1'b0;
    forever begin
      seg = $urandom_range(5, 60);
      mode = $urandom_range(0, 2);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          out_stall <= 1'b1;
          repeat (400) @(posedge clk);
          hold_req = 0;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    #20000000;
    $display("dual_stack_cpu_core_tb NOT OK");
    $finish;
  end

  initial begin
    plan_row_t plan [19];
    plan = '{
      '{KIND_READ,   16'h0000, 8'h00, 1'b1, STAT_IDLE,     16'h0000, 8'h00},
      '{KIND_READ,   16'hffff, 8'h00, 1'b1, STAT_IDLE,     16'h0000, 8'h00},
      '{KIND_LOAD,   16'hffff, 8'hff, 1'b1, STAT_IDLE,     16'h0000, 8'h00},
      '{KIND_READ,   16'hffff, 8'h00, 1'b1, STAT_IDLE,     16'h0000, 8'hff},
      '{KIND_DEVWR,  16'hffff, 8'ha5, 1'b1, STAT_IDLE,     16'h0000, 8'h00},
      '{3'd7,        16'h1234, 8'hff, 1'b1, STAT_IDLE,     16'h0000, 8'h00},
      '{KIND_STEP,   16'h0000, 8'h00, 1'b1, STAT_IDLE,     16'h0000, 8'h00},
      '{KIND_VECTOR, 16'hffff, 8'h00, 1'b1, STAT_RUN,      16'hffff, 8'h00},
      '{KIND_STEP,   16'h0000, 8'h00, 1'b1, STAT_RET_UNDR, 16'h0000, 8'h00},
      '{KIND_STEP,   16'h0000, 8'h00, 1'b1, STAT_RET_UNDR, 16'h0000, 8'h00},
      '{KIND_VECTOR, 16'h0100, 8'h00, 1'b1, STAT_RUN,      16'h0100, 8'h00},
      '{KIND_LOAD,   16'h0100, {3'd0, OP_LIT}, 1'b0, STAT_RUN, 16'h0000, 8'h00},
      '{KIND_LOAD,   16'h0101, 8'h07, 1'b0, STAT_RUN,      16'h0000, 8'h00},
      '{KIND_LOAD,   16'h0102, {3'd0, OP_LIT}, 1'b0, STAT_RUN, 16'h0000, 8'h00},
      '{KIND_LOAD,   16'h0103, 8'h00, 1'b0, STAT_RUN,      16'h0000, 8'h00},
      '{KIND_LOAD,   16'h0104, {3'd0, OP_DIV}, 1'b0, STAT_RUN, 16'h0000, 8'h00},
      '{KIND_STEP,   16'h0000, 8'h00, 1'b0, STAT_RUN,      16'h0000, 8'h00},
      '{KIND_STEP,   16'h0000, 8'h00, 1'b0, STAT_RUN,      16'h0000, 8'h00},
      '{KIND_STEP,   16'h0000, 8'h00, 1'b0, STAT_RUN,      16'h0000, 8'h00}
    };
    for (int i = 0; i < 65536; i++) ram[i] = 8'd0;
    for (int i = 0; i < 256; i++) begin
      dev[i] = 8'd0;
      stk[0][i] = 8'd0;
      stk[1][i] = 8'd0;
    end
    for (int s = 0; s < 2; s++) begin
      top[s] = 8'd0;
      keep[s] = 8'd0;
      flt[s] = FAULT_NONE;
    end
    pc = 16'd0;
    keepm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = 3'd0;
    addr = 16'd0;
    data = 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) begin
      offer(plan[i].kind, plan[i].addr, plan[i].data);
      if (plan[i].chk) begin
        beats_due[beats_due.size() - 1].st = plan[i].st;
        beats_due[beats_due.size() - 1].pc = plan[i].pc;
        beats_due[beats_due.size() - 1].md = plan[i].md;
      end
      pause();
    end
    drain();
    hold_req = 1;
    while (sent < 700) begin
      if ($urandom_range(0, 3) == 0)
        send(3'($urandom), 16'($urandom), 8'($urandom));
      else
        run_program();
      if (sent > 400 && sent < 420) drain();
    end
    drain();
    flood(1'b0);
    flood(1'b1);
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && beats_due.size() == 0) begin
      $display("dual_stack_cpu_core_tb OK");
    end else begin
      $display("dual_stack_cpu_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dsc_pkg.sv
rtl/core/dsc_ram.sv
rtl/core/dsc_ctrl.sv
rtl/core/dsc_dpath.sv
rtl/core/dual_stack_cpu_core.sv
test/dual_stack_cpu_core_tb.sv
